// File: rtl/rfpa_pkg.sv
// shared types and constants of the range frame parser and averager
`timescale 1ns / 1ps

package rfpa_pkg;

  // frame layout
  localparam int unsigned POINTS_PER_FRAME = 12;
  localparam int unsigned POINT_BYTES      = 15;
  localparam int unsigned FRAME_BYTES      = 196;

  localparam logic [7:0] HDR_BYTE  = 8'hAA;
  localparam logic [7:0] FUNC_CODE = 8'h02;
  localparam logic [7:0] FUNC_POS  = 8'd5;
  localparam logic [7:0] DATA_POS  = 8'd10;
  localparam logic [7:0] CHK_POS   = 8'(FRAME_BYTES - 2);
  localparam logic [7:0] LAST_POS  = 8'(FRAME_BYTES - 1);
  localparam logic [7:0] PTS_END   = 8'(10 + POINTS_PER_FRAME * POINT_BYTES);
  localparam logic [7:0] HDR_OFFSET = 8'd4;
  localparam logic [2:0] HDR_COUNT  = 3'd4;
  localparam logic [3:0] WCNT_LAST  = 4'(POINT_BYTES - 1);

  // widths
  localparam int unsigned SUM_W  = 20;
  localparam int unsigned VP_W   = 4;
  localparam int unsigned DIST_W = 16;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned SAFE_W = 13;
  localparam int unsigned OUT_W  = 24;

  // register map
  localparam logic [1:0] REG_SAFE    = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_MAXD    = 2'd2;

  localparam logic [12:0] SAFE_RESET    = 13'd300;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [15:0] MAXD_RESET    = 16'd4000;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_HDR,
    KIND_DATA
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  typedef enum logic [2:0] {
    OUT_NONE      = 3'd0,
    OUT_ACCEPT    = 3'd1,
    OUT_BAD_FUNC  = 3'd2,
    OUT_BAD_SUM   = 3'd3,
    OUT_NO_POINTS = 3'd4
  } outcome_t;

  typedef struct packed {
    logic [SAFE_W-1:0] safe;
    logic [15:0]       timeout;
    logic [15:0]       max_dist;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [VP_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/rfpa_front.sv
// front end: takes stream words and classifies them for the queue
`timescale 1ns / 1ps

module rfpa_front (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                s_tuser,
  input  rfpa_pkg::q_stat_t   q_stat,
  output logic                push,
  output rfpa_pkg::item_t     push_item
);

  assign s_tready = !q_stat.full;
  assign push     = s_tvalid && !q_stat.full;

  always_comb begin
    push_item.data = s_tdata;
    if (s_tuser) begin
      push_item.kind = rfpa_pkg::KIND_TICK;
    end else if (s_tdata == rfpa_pkg::HDR_BYTE) begin
      push_item.kind = rfpa_pkg::KIND_HDR;
    end else begin
      push_item.kind = rfpa_pkg::KIND_DATA;
    end
  end

endmodule

// File: rtl/rfpa_queue.sv
// short fifo between front end and frame engine
`timescale 1ns / 1ps

module rfpa_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rfpa_pkg::item_t   push_item,
  input  logic              pop,
  output rfpa_pkg::item_t   pop_item,
  output rfpa_pkg::q_stat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rfpa_pkg::item_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = (count == CNT_FULL);
  assign stat.empty = (count == '0);
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/rfpa_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rfpa_div (
  input  logic               clk,
  input  logic               rst,
  input  rfpa_pkg::div_req_t req,
  output rfpa_pkg::div_rsp_t rsp
);

  localparam int unsigned N = rfpa_pkg::SUM_W;
  localparam int unsigned D = rfpa_pkg::VP_W;
  localparam logic [4:0]  CNT_LAST = 5'(N - 1);

  logic         busy;
  logic [4:0]   cnt;
  logic [D-1:0] rem;
  logic [D-1:0] dvs;
  logic [N-1:0] quo;
  logic         done;

  logic [D:0]   shifted;
  logic         fits;
  logic [D:0]   diff;

  assign shifted = {rem, quo[N-1]};
  assign fits    = (shifted >= {1'b0, dvs});
  assign diff    = shifted - {1'b0, dvs};

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvs <= req.divisor;
      quo <= req.dividend;
    end else if (busy) begin
      rem <= fits ? diff[D-1:0] : shifted[D-1:0];
      quo <= {quo[N-2:0], fits};
    end
  end

endmodule

// File: rtl/rfpa_back.sv
// frame engine: header hunt, checksum, point averaging, timeout, result word
`timescale 1ns / 1ps

module rfpa_back (
  input  logic                          clk,
  input  logic                          rst,
  input  rfpa_pkg::cfg_t                cfg,
  input  rfpa_pkg::q_stat_t             q_stat,
  input  rfpa_pkg::item_t               item,
  output logic                          pop,
  output rfpa_pkg::div_req_t            div_req,
  input  rfpa_pkg::div_rsp_t            div_rsp,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rfpa_pkg::OUT_W-1:0]    m_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEND
  } state_t;

  state_t state;

  logic [2:0]                    header_matched;
  logic [7:0]                    body_index;
  logic [7:0]                    running_checksum;
  logic                          function_code_ok;
  logic [7:0]                    low_byte_hold;
  logic [rfpa_pkg::SUM_W-1:0]    distance_sum;
  logic [rfpa_pkg::VP_W-1:0]     valid_points;
  logic [3:0]                    wcnt;
  logic [rfpa_pkg::DIST_W-1:0]   current_distance;
  logic                          valid_flag;
  logic [rfpa_pkg::TICK_W-1:0]   ticks_since_update;

  logic                          out_free;
  logic                          tmo;
  logic                          valid_t;
  logic [rfpa_pkg::DIST_W-1:0]   cur_t;
  logic                          is_body;
  logic [7:0]                    b;
  logic [7:0]                    pos;
  logic                          in_pts;
  logic [7:0]                    chk_next;
  logic                          fc_next;
  logic [7:0]                    low_next;
  logic [3:0]                    wcnt_next;
  logic [rfpa_pkg::DIST_W-1:0]   d;
  logic                          d_ok;
  logic [rfpa_pkg::SUM_W-1:0]    sum_next;
  logic [rfpa_pkg::VP_W-1:0]     vp_next;
  logic                          last;
  rfpa_pkg::outcome_t            body_outcome;
  rfpa_pkg::outcome_t            send_outcome;
  logic                          start_div;
  logic                          send_now;
  logic                          out_load;
  logic [rfpa_pkg::OUT_W-1:0]    out_word;

  assign out_free = !m_tvalid || m_tready;
  assign pop      = (state == ST_IDLE) && !q_stat.empty && out_free;

  always_comb begin
    tmo     = valid_flag && (ticks_since_update > cfg.timeout);
    valid_t = tmo ? 1'b0 : valid_flag;
    cur_t   = tmo ? '0 : current_distance;
    b       = item.data;
    is_body = (item.kind != rfpa_pkg::KIND_TICK) && (header_matched == rfpa_pkg::HDR_COUNT);
    pos     = body_index + rfpa_pkg::HDR_OFFSET;

    if (pos < rfpa_pkg::CHK_POS) begin
      chk_next = running_checksum + b;
    end else if (pos == rfpa_pkg::CHK_POS) begin
      chk_next = running_checksum ^ b;
    end else begin
      chk_next = running_checksum;
    end

    fc_next = (pos == rfpa_pkg::FUNC_POS) ? (b == rfpa_pkg::FUNC_CODE) : function_code_ok;

    in_pts    = (pos >= rfpa_pkg::DATA_POS) && (pos < rfpa_pkg::PTS_END);
    low_next  = low_byte_hold;
    wcnt_next = wcnt;
    sum_next  = distance_sum;
    vp_next   = valid_points;
    d         = {b, low_byte_hold};
    d_ok      = (d != '0) && (d <= cfg.max_dist);
    if (in_pts) begin
      wcnt_next = (wcnt == rfpa_pkg::WCNT_LAST) ? 4'd0 : wcnt + 4'd1;
      if (wcnt == 4'd0) begin
        low_next = b;
      end else if (wcnt == 4'd1 && d_ok) begin
        sum_next = distance_sum + rfpa_pkg::SUM_W'(d);
        vp_next  = valid_points + 1'b1;
      end
    end

    last = (pos >= rfpa_pkg::LAST_POS);
    priority if (!fc_next) begin
      body_outcome = rfpa_pkg::OUT_BAD_FUNC;
    end else if (chk_next != 8'd0) begin
      body_outcome = rfpa_pkg::OUT_BAD_SUM;
    end else if (vp_next == '0) begin
      body_outcome = rfpa_pkg::OUT_NO_POINTS;
    end else begin
      body_outcome = rfpa_pkg::OUT_ACCEPT;
    end

    send_outcome = (is_body && last) ? body_outcome : rfpa_pkg::OUT_NONE;
    start_div    = pop && is_body && last && (body_outcome == rfpa_pkg::OUT_ACCEPT);
    send_now     = pop && !start_div;

    // result register load: a plain word from idle, the averaged word after the divide
    out_load = (state == ST_SEND) ? out_free : send_now;
    if (state == ST_SEND) begin
      out_word = {3'b000, rfpa_pkg::OUT_ACCEPT,
                  current_distance < rfpa_pkg::DIST_W'(cfg.safe),
                  1'b1, current_distance};
    end else begin
      out_word = {3'b000, send_outcome,
                  valid_t && (cur_t < rfpa_pkg::DIST_W'(cfg.safe)),
                  valid_t, cur_t};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      header_matched     <= '0;
      body_index         <= '0;
      running_checksum   <= '0;
      function_code_ok   <= 1'b0;
      low_byte_hold      <= '0;
      distance_sum       <= '0;
      valid_points       <= '0;
      wcnt               <= '0;
      current_distance   <= '0;
      valid_flag         <= 1'b0;
      ticks_since_update <= '0;
      div_req            <= '0;
      m_tvalid           <= 1'b0;
      m_tdata            <= '0;
    end else begin
      div_req.start <= start_div;
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= out_word;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            valid_flag       <= valid_t || start_div;
            current_distance <= cur_t;
            if (item.kind == rfpa_pkg::KIND_TICK) begin
              if (ticks_since_update != '1) begin
                ticks_since_update <= ticks_since_update + 1'b1;
              end
            end else if (!is_body) begin
              header_matched <= (item.kind == rfpa_pkg::KIND_HDR) ?
                                header_matched + 3'd1 : 3'd0;
            end else if (!last) begin
              body_index       <= body_index + 8'd1;
              running_checksum <= chk_next;
              function_code_ok <= fc_next;
              low_byte_hold    <= low_next;
              distance_sum     <= sum_next;
              valid_points     <= vp_next;
              wcnt             <= wcnt_next;
            end else begin
              header_matched   <= '0;
              body_index       <= '0;
              running_checksum <= '0;
              function_code_ok <= 1'b0;
              low_byte_hold    <= '0;
              distance_sum     <= '0;
              valid_points     <= '0;
              wcnt             <= '0;
              if (start_div) begin
                ticks_since_update <= '0;
                div_req.dividend   <= sum_next;
                div_req.divisor    <= vp_next;
                state              <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            current_distance <= div_rsp.quotient[rfpa_pkg::DIST_W-1:0];
            state            <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/range_frame_parser_averager.sv
// top level of the rangefinder frame parser and distance averager
`timescale 1ns / 1ps

// path: each accepted word passes the queue, then its result word is registered;
//   a good frame's last byte first goes through the one-bit-per-cycle divider
// throughput: one word per cycle while the result stream is not stalled, except
//   after a good frame, while the divider holds the engine and the queue fills up
// reset: synchronous active-high rst empties the queue, clears parser state and
//   distance, and loads the config registers with 300 / 500 / 4000

module range_frame_parser_averager #(
  parameter int unsigned QUEUE_DEPTH = 4   // words buffered between front and engine
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] rx_byte
  input  logic        s_tuser,    // [0] op: 0 byte, 1 millisecond tick
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [15:0] distance, [16] distance_valid,
                                  // [17] obstacle_near, [20:18] frame_outcome
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rfpa_pkg::cfg_t     cfg;
  rfpa_pkg::q_stat_t  q_stat;
  rfpa_pkg::item_t    push_item;
  rfpa_pkg::item_t    pop_item;
  rfpa_pkg::div_req_t div_req;
  rfpa_pkg::div_rsp_t div_rsp;
  logic               push;
  logic               pop;
  logic               cfg_wr;

  // config registers, word addressed by paddr[3:2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.safe     <= rfpa_pkg::SAFE_RESET;
      cfg.timeout  <= rfpa_pkg::TIMEOUT_RESET;
      cfg.max_dist <= rfpa_pkg::MAXD_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        rfpa_pkg::REG_SAFE:    cfg.safe     <= pwdata[12:0];
        rfpa_pkg::REG_TIMEOUT: cfg.timeout  <= pwdata[15:0];
        rfpa_pkg::REG_MAXD:    cfg.max_dist <= pwdata[15:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  // read back, zero-extended
  always_comb begin
    unique case (paddr[3:2])
      rfpa_pkg::REG_SAFE:    prdata = {19'd0, cfg.safe};
      rfpa_pkg::REG_TIMEOUT: prdata = {16'd0, cfg.timeout};
      rfpa_pkg::REG_MAXD:    prdata = {16'd0, cfg.max_dist};
      default:               prdata = 32'd0;
    endcase
  end

  // front end tags each word as tick, header byte or other byte
  rfpa_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue so input keeps flowing while the engine divides, until it is full
  rfpa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  // frame engine owns the result register
  rfpa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .item     (pop_item),
    .pop      (pop),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // average = point sum / point count
  rfpa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

// File: rtl/rfpa_checker.sv
// port-level checks for the range frame parser and averager
`timescale 1ns / 1ps

module rfpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        pready
);

  // obstacle only on a valid distance
  a_obstacle_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[17]) |-> m_tdata[16])
    else $error("obstacle_near without distance_valid");

  // a cleared distance reads as zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[16]) |-> (m_tdata[15:0] == 16'd0))
    else $error("nonzero distance while not valid");

  // an accepted frame leaves the distance valid
  a_accept_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[20:18] == rfpa_pkg::OUT_ACCEPT) |-> m_tdata[16])
    else $error("accepted frame without valid distance");

  // only defined outcome codes and zero padding, with pready high
  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[20:18] <= rfpa_pkg::OUT_NO_POINTS) &&
                  (m_tdata[23:21] == 3'd0) && pready))
    else $error("undefined outcome code or padding");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result word changed while stalled");

endmodule

bind range_frame_parser_averager rfpa_checker u_rfpa_checker (.*);

// File: verif/tb.sv
// self-checking testbench for the rangefinder frame parser and distance averager
`timescale 1ns / 1ps

module tb;

  localparam int CLK_PERIOD     = 10;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either stream
  localparam int DRAIN_CYCLES   = 40;    // well past the divider latency of a good frame
  localparam int REPORT_LIMIT   = 10;

  // op codes carried on s_tuser
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // one result word, split into its fields
  typedef struct packed {
    logic [15:0]        distance;
    logic               valid;
    logic               near;
    rfpa_pkg::outcome_t outcome;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] rx_byte
  logic        s_tuser = 1'b0; // [0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [15:0] distance, [16] valid, [17] near, [20:18] outcome
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  range_frame_parser_averager i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: parser, averager and config copy
  // ---------------------------------------------------------------------------
  logic [2:0]  hdr_seen;
  logic [7:0]  body_cnt;
  logic [7:0]  sum_acc;
  logic        func_good;
  logic [7:0]  lo_hold;
  logic [19:0] dist_acc;
  logic [3:0]  pt_count;
  logic [15:0] dist_now;
  logic        dist_ok;
  logic [15:0] tick_age;
  logic [12:0] safe_mm;
  logic [15:0] timeout_lim;
  logic [15:0] max_mm;

  reading_t expected_readings[$];
  int       err_count  = 0;
  bit       bursts_on  = 1'b1;  // random idling on both streams
  int       stall_left = 0;
  int       quiet_cycles = 0;

  // parser back to header hunt with an empty frame accumulator
  function automatic void clear_frame();
    hdr_seen  = '0;
    body_cnt  = '0;
    sum_acc   = '0;
    func_good = 1'b0;
    lo_hold   = '0;
    dist_acc  = '0;
    pt_count  = '0;
  endfunction

  function automatic void reset_model();
    clear_frame();
    dist_now    = '0;
    dist_ok     = 1'b0;
    tick_age    = '0;
    safe_mm     = rfpa_pkg::SAFE_RESET;
    timeout_lim = rfpa_pkg::TIMEOUT_RESET;
    max_mm      = rfpa_pkg::MAXD_RESET;
  endfunction

  // advance the parser by one word and return the result word it produces
  function automatic reading_t predict_reading(input logic op, input logic [7:0] b);
    reading_t           r;
    rfpa_pkg::outcome_t res;
    logic [7:0]         pos;
    logic [7:0]         rel;
    logic [7:0]         pt_byte;
    logic [15:0]        d;
    res = rfpa_pkg::OUT_NONE;
    // stale distance is dropped before the word itself is handled
    if (dist_ok && tick_age > timeout_lim) begin
      dist_now = '0;
      dist_ok  = 1'b0;
    end
    if (op == OP_TICK) begin
      if (tick_age != 16'hFFFF) tick_age++;
    end else if (hdr_seen < rfpa_pkg::HDR_COUNT) begin
      hdr_seen = (b == rfpa_pkg::HDR_BYTE) ? hdr_seen + 3'd1 : 3'd0;
    end else begin
      pos = body_cnt + rfpa_pkg::HDR_OFFSET;
      // checksum byte is folded in by xor so a match leaves zero
      if (pos < rfpa_pkg::CHK_POS) sum_acc = sum_acc + b;
      else if (pos == rfpa_pkg::CHK_POS) sum_acc = sum_acc ^ b;
      if (pos == rfpa_pkg::FUNC_POS) func_good = (b == rfpa_pkg::FUNC_CODE);
      if (pos >= rfpa_pkg::DATA_POS && pos < rfpa_pkg::PTS_END) begin
        rel     = pos - rfpa_pkg::DATA_POS;
        pt_byte = 8'(rel % rfpa_pkg::POINT_BYTES);
        if (pt_byte == 8'd0) begin
          lo_hold = b;
        end else if (pt_byte == 8'd1) begin
          d = {b, lo_hold};
          if (d != 16'd0 && d <= max_mm) begin
            dist_acc = dist_acc + 20'(d);
            pt_count = pt_count + 4'd1;
          end
        end
      end
      if (pos >= rfpa_pkg::LAST_POS) begin
        // function code beats checksum, checksum beats empty point set
        if (!func_good) begin
          res = rfpa_pkg::OUT_BAD_FUNC;
        end else if (sum_acc != 8'd0) begin
          res = rfpa_pkg::OUT_BAD_SUM;
        end else if (pt_count == 4'd0) begin
          res = rfpa_pkg::OUT_NO_POINTS;
        end else begin
          dist_now = 16'(dist_acc / pt_count);
          dist_ok  = 1'b1;
          tick_age = '0;
          res      = rfpa_pkg::OUT_ACCEPT;
        end
        clear_frame();
      end else begin
        body_cnt++;
      end
    end
    r.distance = dist_now;
    r.valid    = dist_ok;
    r.near     = dist_ok && (16'(safe_mm) > dist_now);
    r.outcome  = res;
    return r;
  endfunction

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: every accepted result word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.distance = m_tdata[15:0];
      got.valid    = m_tdata[16];
      got.near     = m_tdata[17];
      got.outcome  = rfpa_pkg::outcome_t'(m_tdata[20:18]);
      if (expected_readings.size() == 0) begin
        note_error($sformatf("result word with nothing expected: %h", m_tdata));
      end else begin
        want = expected_readings.pop_front();
        if (got.distance !== want.distance || got.valid !== want.valid ||
            got.near !== want.near || got.outcome !== want.outcome)
          note_error($sformatf({"expected dist %0d valid %0b near %0b outcome %0d, ",
                                "got dist %0d valid %0b near %0b outcome %0d"},
                               want.distance, want.valid, want.near, want.outcome,
                               got.distance, got.valid, got.near, got.outcome));
      end
    end
  end

  // receiver side: random stall bursts that drop m_tready
  always @(negedge clk) begin
    if (stall_left == 0 && bursts_on && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 18);
    m_tready = (stall_left == 0);
    if (stall_left != 0) stall_left--;
  end

  // watchdog: ends the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one word, with an optional idle gap first, and wait for its handshake
  task automatic send_word(input logic op, input logic [7:0] b);
    int gap;
    gap = 0;
    if (bursts_on && $urandom_range(0, 11) == 0) gap = $urandom_range(1, 18);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = b;
    expected_readings.push_back(predict_reading(op, b));
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering, let every result drain and the divider settle
  task automatic wait_quiet();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // read a register back and compare with the predictor's copy
  task automatic read_reg(input logic [1:0] idx);
    logic [31:0] rdata;
    logic [31:0] want;
    apb_access(1'b0, idx, '0, rdata);
    unique case (idx)
      rfpa_pkg::REG_SAFE:    want = 32'(safe_mm);
      rfpa_pkg::REG_TIMEOUT: want = 32'(timeout_lim);
      default:               want = 32'(max_mm);
    endcase
    if (rdata !== want)
      note_error($sformatf("register %0d read %0d, expected %0d", idx, rdata, want));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] unused;
    apb_access(1'b1, idx, value, unused);
    unique case (idx)
      rfpa_pkg::REG_SAFE:    safe_mm     = value[12:0];
      rfpa_pkg::REG_TIMEOUT: timeout_lim = value[15:0];
      default:               max_mm      = value[15:0];
    endcase
    read_reg(idx);
  endtask

  task automatic set_config(input int safe, input int timeout, input int maxd);
    wait_quiet();
    write_reg(rfpa_pkg::REG_SAFE, 32'(safe));
    write_reg(rfpa_pkg::REG_TIMEOUT, 32'(timeout));
    write_reg(rfpa_pkg::REG_MAXD, 32'(maxd));
  endtask

  // build one full frame with random content and the requested defects, then send
  // it with the odd tick slipped in between bytes
  task automatic send_frame(input bit bad_func, input bit bad_sum, input bit no_pts);
    logic [7:0]  frame [rfpa_pkg::FRAME_BYTES];
    logic [7:0]  sum;
    logic [15:0] d;
    logic [15:0] hi;
    int          base;
    int          sel;
    int          tick_pct;
    // get the parser back to a clean header hunt first
    while (hdr_seen != 3'd0) send_word(OP_BYTE, 8'h00);
    foreach (frame[i]) frame[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < rfpa_pkg::HDR_COUNT; i++) frame[i] = rfpa_pkg::HDR_BYTE;
    frame[rfpa_pkg::FUNC_POS] = rfpa_pkg::FUNC_CODE;
    if (bad_func) begin
      frame[rfpa_pkg::FUNC_POS] = 8'($urandom_range(0, 255));
      if (frame[rfpa_pkg::FUNC_POS] == rfpa_pkg::FUNC_CODE) frame[rfpa_pkg::FUNC_POS] = 8'h03;
    end
    // either a near cluster or the whole allowed range
    hi = max_mm;
    if ($urandom_range(0, 1) == 1 && max_mm > 16'd600) hi = 16'd600;
    for (int p = 0; p < rfpa_pkg::POINTS_PER_FRAME; p++) begin
      base = rfpa_pkg::DATA_POS + p * rfpa_pkg::POINT_BYTES;
      sel  = $urandom_range(0, 7);
      if (no_pts) begin
        if (max_mm == 16'hFFFF || sel[0]) d = 16'd0;
        else d = 16'($urandom_range(max_mm + 1, 65535));
      end else if (p == 0 || sel >= 3) begin
        d = 16'($urandom_range(1, hi));
      end else if (sel == 0) begin
        d = 16'd0;
      end else if (sel == 1 || max_mm == 16'hFFFF) begin
        d = max_mm;
      end else begin
        d = 16'($urandom_range(max_mm + 1, 65535));
      end
      frame[base]     = d[7:0];
      frame[base + 1] = d[15:8];
    end
    sum = '0;
    for (int i = rfpa_pkg::HDR_OFFSET; i < rfpa_pkg::CHK_POS; i++) sum = sum + frame[i];
    frame[rfpa_pkg::CHK_POS] = bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum;
    tick_pct = $urandom_range(0, 3);
    foreach (frame[i]) begin
      if ($urandom_range(0, 99) < tick_pct) send_word(OP_TICK, 8'($urandom_range(0, 255)));
      send_word(OP_BYTE, frame[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_reset_values();
    read_reg(rfpa_pkg::REG_SAFE);
    read_reg(rfpa_pkg::REG_TIMEOUT);
    read_reg(rfpa_pkg::REG_MAXD);
  endtask

  // byte extremes, both ops and broken header runs
  task automatic test_directed_words();
    send_word(OP_TICK, 8'hFF);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, rfpa_pkg::HDR_BYTE);
    send_word(OP_BYTE, 8'h55);      // hunt restarts after one header byte
    send_word(OP_BYTE, rfpa_pkg::HDR_BYTE);
    send_word(OP_BYTE, rfpa_pkg::HDR_BYTE);
    send_word(OP_BYTE, rfpa_pkg::HDR_BYTE);
    send_word(OP_BYTE, 8'h01);      // and after three
    send_word(OP_BYTE, rfpa_pkg::HDR_BYTE);
    send_word(OP_TICK, rfpa_pkg::HDR_BYTE);   // a tick does not disturb the hunt
    send_word(OP_BYTE, rfpa_pkg::HDR_BYTE);
    send_word(OP_BYTE, 8'h7F);
    send_word(OP_BYTE, 8'h80);
    send_word(OP_TICK, 8'h00);
  endtask

  // good frame, then both defect priorities
  task automatic test_frame_outcomes();
    send_frame(1'b0, 1'b0, 1'b0);
    send_frame(1'b1, 1'b1, 1'b1);
    send_frame(1'b0, 1'b1, 1'b1);
  endtask

  // short timeout: ticks age the held distance past it, then register extremes
  task automatic test_timeout();
    set_config(4096, 3, 65535);
    repeat (6) send_word(OP_TICK, 8'($urandom_range(0, 255)));
    send_word(OP_BYTE, 8'h00);
    set_config(0, 65535, 1);
  endtask

  // closing stretch with no idling at all
  task automatic test_quiet_run();
    set_config($urandom_range(0, 4096), $urandom_range(0, 20), $urandom_range(600, 4000));
    bursts_on = 1'b0;
    send_frame(1'b0, 1'b0, 1'b1);
    repeat (4) send_word(OP_TICK, 8'h00);
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_values();
    test_directed_words();
    test_frame_outcomes();
    test_timeout();
    test_quiet_run();
    wait_quiet();
    if (err_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: range_frame_parser_averager.f
rtl/rfpa_pkg.sv
rtl/rfpa_front.sv
rtl/rfpa_queue.sv
rtl/rfpa_div.sv
rtl/rfpa_back.sv
rtl/range_frame_parser_averager.sv
rtl/rfpa_checker.sv
verif/tb.sv
